[src/mpi_pkg.sv]
// Shared widths, command and ALU operation codes and handshake structs of the modular power and inverse unit.
package mpi_pkg;

  localparam int W  = 32;
  localparam int CW = $clog2(W);

  typedef enum logic [0:0] {
    CMD_POW = 1'b0,
    CMD_INV = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic            start;
    alu_op_t         op;
    logic [W-1:0]    a;
    logic [W-1:0]    b;
    logic [W-1:0]    d;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

[src/mpi_alu.sv]
// Bit-serial shift-and-add unit shared by modular multiply and restoring divide.
module mpi_alu import mpi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  alu_req_t     req,
  output alu_rsp_t     rsp,
  output logic [W-1:0] rem,
  output logic [W-1:0] quo
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  alu_op_t       op_r, op_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  b_r, b_nxt;

  logic [W+1:0]  addend;
  logic [W+1:0]  sum;
  logic [W+1:0]  d1;
  logic [W+1:0]  d2;
  logic          ge1;
  logic          ge2;
  logic [W+1:0]  step;

  // One step: acc = 2*acc + addend, then bring it below the divisor. For a
  // multiply the addend is the multiplicand when the next multiplier bit is
  // set; for a divide it is the next dividend bit, and the compare result
  // is the quotient bit.
  always_comb begin
    if (op_r == ALU_MUL) begin
      addend = b_r[W-1] ? {2'b00, a_r} : '0;
    end else begin
      addend = {{(W+1){1'b0}}, b_r[W-1]};
    end
    sum  = {1'b0, acc_r, 1'b0} + addend;
    d1   = {2'b00, d_r};
    d2   = {1'b0, d_r, 1'b0};
    ge1  = (sum >= d1);
    ge2  = (sum >= d2);
    if (ge2) begin
      step = sum - d2;
    end else if (ge1) begin
      step = sum - d1;
    end else begin
      step = sum;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = req.op;
      a_nxt    = req.a;
      d_nxt    = req.d;
      acc_nxt  = '0;
      b_nxt    = req.b;
    end else if (busy_r) begin
      acc_nxt = step[W-1:0];
      b_nxt   = {b_r[W-2:0], ge1};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rem      = acc_r;
  assign quo      = b_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !done_r)
    else $error("alu reports done while still busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !req.start |-> acc_r < d_r || d_r == '0)
    else $error("alu accumulator escaped its divisor range");

  assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r && cnt_r == '0)
    else $error("alu did not begin a new operation");

endmodule

[src/modular_power_and_inverse_unit.sv]
// Top level of the modular power and inverse unit: handshakes, modulus register and sequencer.
//
//   Channel  Direction  Handshake             Payload
//   in_      slave      in_tvalid/in_tready   tdata: base_value, exponent; tuser: command
//   out_     master     out_tvalid/out_tready tdata: result; tuser: not_invertible
//   cfg_     slave      cfg_valid/cfg_ready   cfg_data: modulus
//
// Every modular multiply, and every quotient and remainder, comes from one
// bit-serial unit. A power first reduces the base, then for each exponent bit up to
// the highest set one it squares, with a multiply before the square where the bit is set;
// an inverse reduces the value, then runs a divide and a multiply per Euclid step,
// with at most 45 steps for 32-bit operands. A zero modulus skips the unit and
// goes straight to the emit state.
// Reset loads the modulus with 1 and empties the output register. The input
// is not ready while an item is at work; a finished result waits in the
// output register, and the next item may be taken meanwhile.
module modular_power_and_inverse_unit import mpi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  // Input channel.
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [2*W-1:0] in_tdata,   // [31:0] base_value, [63:32] exponent
  input  logic           in_tuser,   // [0] command
  // Result channel.
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [W-1:0]   out_tdata,  // [31:0] result
  output logic           out_tuser,  // [0] not_invertible
  // Configuration channel.
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [W-1:0]   cfg_data
);

  // Sequencer states. The W-states wait for the shared unit to finish.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WRED  = 9'b000000010,
    S_PLOOP = 9'b000000100,
    S_WMULA = 9'b000001000,
    S_WMULS = 9'b000010000,
    S_ELOOP = 9'b000100000,
    S_WDIV  = 9'b001000000,
    S_WMULT = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t       state_r, state_nxt;
  logic [W-1:0] modulus_r, modulus_nxt;
  logic         cmd_r, cmd_nxt;
  logic [W-1:0] e_r, e_nxt;
  // Power: u_r is the running product, y_r the running square.
  // Inverse: x_r/y_r are the remainders r0/r1, u_r/v_r the coefficients t0/t1.
  logic [W-1:0] x_r, x_nxt;
  logic [W-1:0] y_r, y_nxt;
  logic [W-1:0] u_r, u_nxt;
  logic [W-1:0] v_r, v_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         flag_r, flag_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;
  logic         out_flag_r, out_flag_nxt;

  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [W-1:0] alu_rem;
  logic [W-1:0] alu_quo;

  logic [W-1:0] one_mod;
  logic [W:0]   t_diff;
  logic [W-1:0] t_next;
  logic         in_xfer;
  logic         out_free;

  mpi_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp),
    .rem   (alu_rem),
    .quo   (alu_quo)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

  // 1 reduced by the modulus: zero only for modulus one.
  assign one_mod = {{(W-1){1'b0}}, (modulus_r != W'(1))};

  // t2 = (t0 - q*t1) mod m, with the product already reduced by the unit.
  assign t_diff = {1'b0, u_r} - {1'b0, alu_rem};
  assign t_next = t_diff[W] ? (t_diff[W-1:0] + modulus_r) : t_diff[W-1:0];

  always_comb begin
    state_nxt     = state_r;
    modulus_nxt   = modulus_r;
    cmd_nxt       = cmd_r;
    e_nxt         = e_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_flag_nxt  = out_flag_r;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_req.a     = u_r;
    alu_req.b     = y_r;
    alu_req.d     = modulus_r;

    if (cfg_valid && cfg_ready) begin
      modulus_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt = in_tuser;
          e_nxt   = in_tdata[2*W-1:W];
          if (modulus_r == '0) begin
            // No reduction possible: power gives 0, inverse is refused.
            res_nxt   = '0;
            flag_nxt  = (in_tuser == CMD_INV);
            state_nxt = S_EMIT;
          end else begin
            // Reduce the value by the modulus first.
            alu_req.start = 1'b1;
            alu_req.op    = ALU_DIV;
            alu_req.b     = in_tdata[W-1:0];
            alu_req.d     = modulus_r;
            x_nxt         = modulus_r;
            u_nxt         = (in_tuser == CMD_POW) ? one_mod : '0;
            v_nxt         = one_mod;
            state_nxt     = S_WRED;
          end
        end
      end
      S_WRED: begin
        if (alu_rsp.done) begin
          y_nxt     = alu_rem;
          state_nxt = (cmd_r == CMD_INV) ? S_ELOOP : S_PLOOP;
        end
      end
      S_PLOOP: begin
        if (e_r == '0) begin
          res_nxt   = u_r;
          flag_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end else if (e_r[0]) begin
          alu_req.start = 1'b1;
          alu_req.a     = u_r;
          alu_req.b     = y_r;
          state_nxt     = S_WMULA;
        end else begin
          alu_req.start = 1'b1;
          alu_req.a     = y_r;
          alu_req.b     = y_r;
          state_nxt     = S_WMULS;
        end
      end
      S_WMULA: begin
        if (alu_rsp.done) begin
          u_nxt         = alu_rem;
          alu_req.start = 1'b1;
          alu_req.a     = y_r;
          alu_req.b     = y_r;
          state_nxt     = S_WMULS;
        end
      end
      S_WMULS: begin
        if (alu_rsp.done) begin
          y_nxt     = alu_rem;
          e_nxt     = {1'b0, e_r[W-1:1]};
          state_nxt = S_PLOOP;
        end
      end
      S_ELOOP: begin
        if (y_r == '0) begin
          // Euclid has ended; r0 is the gcd.
          if (x_r != W'(1)) begin
            res_nxt  = '0;
            flag_nxt = 1'b1;
          end else begin
            res_nxt  = u_r;
            flag_nxt = 1'b0;
          end
          state_nxt = S_EMIT;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.b     = x_r;
          alu_req.d     = y_r;
          state_nxt     = S_WDIV;
        end
      end
      S_WDIV: begin
        if (alu_rsp.done) begin
          // Shift the remainders and form q * t1 mod m.
          x_nxt         = y_r;
          y_nxt         = alu_rem;
          alu_req.start = 1'b1;
          alu_req.op    = ALU_MUL;
          alu_req.a     = v_r;
          alu_req.b     = alu_quo;
          alu_req.d     = modulus_r;
          state_nxt     = S_WMULT;
        end
      end
      S_WMULT: begin
        if (alu_rsp.done) begin
          u_nxt     = v_r;
          v_nxt     = t_next;
          state_nxt = S_ELOOP;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_flag_nxt  = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    e_r        <= e_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    flag_r     <= flag_nxt;
    out_data_r <= out_data_nxt;
    out_flag_r <= out_flag_nxt;
  end

  // The shared unit is only started when it is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  // A waiting state always has an operation in flight or just finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRED || state_r == S_WMULA || state_r == S_WMULS ||
     state_r == S_WDIV || state_r == S_WMULT) |-> alu_rsp.busy || alu_rsp.done)
    else $error("sequencer waits on an idle shared unit");

  // Running product and square stay reduced during a power.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PLOOP |-> u_r < modulus_r && y_r < modulus_r)
    else $error("power operands not reduced");

  // Bezout coefficients stay reduced during an inverse.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ELOOP |-> u_r < modulus_r && v_r < modulus_r)
    else $error("inverse coefficients not reduced");

endmodule

[bench/tb_modular_power_and_inverse_unit.sv]
// Self-checking testbench for the modular power and inverse unit, driven over its stream ports.
module tb_modular_power_and_inverse_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mpi_pkg::*;

  // One answer of the unit: the residue and the not-invertible flag.
  typedef struct packed {
    logic [W-1:0] value;
    logic         flag;
  } mod_answer_t;

  // Clock, reset and every input of the block start at known values.
  logic           clk        = 1'b0;
  logic           rst_n      = 1'b0;
  logic           in_tvalid  = 1'b0;
  logic           in_tready;
  logic [2*W-1:0] in_tdata   = '0;   // [31:0] base_value, [63:32] exponent
  logic           in_tuser   = 1'b0; // [0] command
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [W-1:0]   out_tdata;         // [31:0] result
  logic           out_tuser;         // [0] not_invertible
  logic           cfg_valid  = 1'b0;
  logic           cfg_ready;
  logic [W-1:0]   cfg_data   = '0;

  // Chance, in percent, that either side idles in a given cycle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The modulus the predictor works with; it follows every configuration
  // transfer seen on the port, starting from the reset value.
  logic [W-1:0] active_modulus = 1;
  // The modulus the stimulus was last told to write, used to shape values.
  logic [W-1:0] modulus_setting = 1;

  // Answers predicted at input transfers, waiting for their result transfers.
  mod_answer_t pending_results[$];

  int items_sent     = 0;
  int results_seen   = 0;
  int flagged_count  = 0;
  int modulus_writes = 0;
  int error_count    = 0;

  modular_power_and_inverse_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor. Operands never exceed 32 bits, so every product fits in 64
  // bits and can be reduced directly.
  // ---------------------------------------------------------------------------

  // Right-to-left square-and-multiply. A zero modulus cannot reduce anything,
  // so the unit answers zero there.
  function automatic mod_answer_t raise_mod(logic [W-1:0] base, logic [W-1:0] exponent,
                                            logic [W-1:0] m);
    longint unsigned acc, sq, mm;
    int i;
    mod_answer_t ans;
    ans.value = '0;
    ans.flag  = 1'b0;
    if (m == 0) return ans;
    mm  = m;
    acc = 1 % mm;
    sq  = base % mm;
    for (i = 0; i < W; i++) begin
      if (exponent[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    ans.value = acc[W-1:0];
    return ans;
  endfunction

  // Extended Euclid with the Bezout coefficient kept as a residue, so it is
  // already in range when the gcd turns out to be one.
  function automatic mod_answer_t invert_mod(logic [W-1:0] v, logic [W-1:0] m);
    longint unsigned mm, r_prev, r_cur, r_next, q, t_prev, t_cur, t_next;
    mod_answer_t ans;
    ans.value = '0;
    ans.flag  = 1'b1;
    if (m == 0) return ans;
    mm     = m;
    r_prev = mm;
    r_cur  = v;
    r_cur  = r_cur % mm;
    t_prev = 0;
    t_cur  = 1 % mm;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      t_next = (t_prev + mm - (t_cur * q) % mm) % mm;
      r_prev = r_cur;
      r_cur  = r_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    if (r_prev != 1) return ans;
    t_prev    = t_prev % mm;
    ans.value = t_prev[W-1:0];
    ans.flag  = 1'b0;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor and checker. Everything is sampled at the rising edge,
  // where all ports still hold the values that the edge acts on.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    mod_answer_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) active_modulus = cfg_data;
      if (in_tvalid && in_tready) begin
        if (cmd_t'(in_tuser) == CMD_POW)
          pending_results.push_back(raise_mod(in_tdata[W-1:0], in_tdata[2*W-1:W],
                                              active_modulus));
        else
          pending_results.push_back(invert_mod(in_tdata[W-1:0], active_modulus));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser) flagged_count++;
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result transfer with nothing expected: result %h flag %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== want.value) begin
            error_count++;
            $display("%0t: result mismatch: expected %h, actual %h",
                     $time, want.value, out_tdata);
          end
          if (out_tuser !== want.flag) begin
            error_count++;
            $display("%0t: not_invertible mismatch: expected %b, actual %b",
                     $time, want.flag, out_tuser);
          end
        end
      end
    end
  end

  // The receiver stalls at random, at the rate the current phase asks for.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks.
  // ---------------------------------------------------------------------------

  // Presents one item and returns at the edge of its transfer. Valid is left
  // high so that the next item can follow back to back; a random idle gap,
  // when drawn, lowers it first.
  task automatic send_item(cmd_t cmd, logic [W-1:0] value, logic [W-1:0] exponent);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {exponent, value};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops sending and waits until every item sent so far has its result.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  // Writes the modulus once the unit has gone idle.
  task automatic write_modulus(logic [W-1:0] m);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    modulus_setting = m;
    modulus_writes++;
  endtask

  function automatic logic [W-1:0] pick_modulus();
    case ($urandom_range(5))
      0:       return '1;
      1:       return 32'hFFFF_FFFB;                       // largest 32-bit prime
      2:       return $urandom | 32'h1;                    // odd, full width
      3:       return $urandom_range(32'h7FFF_FFFF, 1) << 1; // even, never zero
      4:       return $urandom_range(65535, 2);
      default: return $urandom_range(40, 1);
    endcase
  endfunction

  // Values cluster on zero, all ones and the modulus itself, so reduction and
  // non-invertible cases come up often.
  function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return m;
      3:       return m - 1;
      4:       return (m != 0) ? $urandom % m : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Exponents get a random bit length, so long powers stay a minority and
  // the run time stays reasonable; the top bit of that length is always set.
  function automatic logic [W-1:0] pick_exponent();
    int bits;
    logic [W-1:0] e;
    bits = $urandom_range(W, 0);
    if (bits == 0) return '0;
    e = $urandom;
    if (bits < W) e = e & ((32'h1 << bits) - 1);
    e[bits-1] = 1'b1;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // The modulus comes out of reset as one: every answer is zero and nothing
  // is flagged.
  task automatic test_reset_modulus();
    send_item(CMD_POW, 32'd7, 32'd3);
    send_item(CMD_INV, 32'd5, 32'd0);
  endtask

  // Powers near the top of the range, a zero exponent, and bases that are
  // not below the modulus.
  task automatic test_power_cases();
    write_modulus(32'hFFFF_FFFB);
    send_item(CMD_POW, 32'd2,          32'hFFFF_FFFA); // Fermat: answer is one
    send_item(CMD_POW, 32'hFFFF_FFFF,  32'd0);
    send_item(CMD_POW, 32'd0,          32'd0);
    send_item(CMD_POW, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    write_modulus(32'hFFFF_FFFF);
    send_item(CMD_POW, 32'hFFFF_FFFE,  32'hFFFF_FFFF);
    send_item(CMD_POW, 32'h1234_5678,  32'h0000_0010);
  endtask

  // Inverses: value zero, value one, a value above the modulus, and values
  // that share a factor with the modulus.
  task automatic test_inverse_cases();
    write_modulus(32'hFFFF_FFFB);
    send_item(CMD_INV, 32'd0,         32'd0);
    send_item(CMD_INV, 32'd1,         32'hFFFF_FFFF);
    send_item(CMD_INV, 32'hFFFF_FFFF, 32'd0);
    send_item(CMD_INV, 32'hFFFF_FFFA, 32'd0);
    write_modulus(32'hFFFF_FFFF);                 // 3 * 5 * 17 * 257 * 65537
    send_item(CMD_INV, 32'd3,         32'd0);
    send_item(CMD_INV, 32'd2,         32'd0);
    write_modulus(32'h0001_0000);
    send_item(CMD_INV, 32'h0000_8000, 32'd0);
    send_item(CMD_INV, 32'h0000_1235, 32'd0);
  endtask

  // A zero modulus cannot reduce: powers answer zero, inverses are flagged.
  // Modulus two is the smallest one that still leaves a nonzero residue.
  task automatic test_small_moduli();
    write_modulus(32'd0);
    send_item(CMD_POW, 32'd5, 32'd3);
    send_item(CMD_INV, 32'd5, 32'd0);
    write_modulus(32'd2);
    send_item(CMD_POW, 32'd3, 32'd1);
    send_item(CMD_INV, 32'd1, 32'd0);
  endtask

  // Random commands and operands over several moduli. Every modulus change
  // makes the sender hold off until all outstanding results are back.
  task automatic test_random_traffic(int send_pct, int recv_pct, int settings,
                                     int per_setting);
    int s, k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (s = 0; s < settings; s++) begin
      write_modulus(pick_modulus());
      for (k = 0; k < per_setting; k++)
        send_item(cmd_t'($urandom_range(1)), pick_value(modulus_setting),
                  pick_exponent());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items run under the first idling pattern.
    send_idle_pct = 26;
    recv_idle_pct = 70;
    test_reset_modulus();
    test_power_cases();
    test_inverse_cases();
    test_small_moduli();

    test_random_traffic(26, 70, 6, 14);
    test_random_traffic(70, 26, 6, 14);
    test_random_traffic(0,  0,  6, 14);

    // Let any stray result show up before the verdict.
    wait_for_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end

    $display("Covered %0d items under %0d modulus writes, powers and inverses mixed.",
             items_sent, modulus_writes);
    $display("Checked %0d results, %0d of them flagged as not invertible.",
             results_seen, flagged_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A correct run needs under 20 ms even if every item took the longest
  // inverse path.
  initial begin
    #100_000_000;
    $display("%0t: timeout, %0d items sent, %0d results seen", $time, items_sent,
             results_seen);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
